// ===== sv/closest_point_pair_core_assert.svh =====
// ----------------------------------------------------------------------------
// closest_point_pair_core_assert: assertion macros
// Clocked implication checks shared by the closest point pair RTL.
// ----------------------------------------------------------------------------
`ifndef CLOSEST_POINT_PAIR_CORE_ASSERT_SVH
`define CLOSEST_POINT_PAIR_CORE_ASSERT_SVH

// same-cycle implication
`define CPP_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("closest_point_pair_core: check failed");

// next-cycle implication
`define CPP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("closest_point_pair_core: check failed");

`endif

// ===== sv/cpp_pkg.sv =====
// ----------------------------------------------------------------------------
// cpp_pkg
// Types, widths and the pending-distance merge shared by the closest pair
// cells and the core.
// ----------------------------------------------------------------------------
package cpp_pkg;

    localparam int COORD_BITS     = 16;
    localparam int SQ_BITS        = 2 * COORD_BITS;
    localparam int DIST_BITS      = 2 * COORD_BITS + 1;
    localparam int BEST_BITS      = DIST_BITS + 1;
    localparam int DEF_MAX_POINTS = 64;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        coord_t point_x;
        coord_t point_y;
        logic   last_point;
    } point_in_t;

    typedef struct packed {
        coord_t                first_x;
        coord_t                first_y;
        coord_t                second_x;
        coord_t                second_y;
        logic [DIST_BITS-1:0]  dist_squared;
        logic                  pair_valid;
        logic                  overflowed;
    } result_t;

    // beat moving down the cell chain
    typedef struct packed {
        logic                  valid;
        coord_t                x;
        coord_t                y;
        logic [BEST_BITS-1:0]  best_dist;
        coord_t                best_x;
        coord_t                best_y;
        logic                  pend_valid;
        logic [SQ_BITS-1:0]    pend_sx;
        logic [SQ_BITS-1:0]    pend_sy;
        coord_t                pend_x;
        coord_t                pend_y;
    } token_t;

    // fold the squares left by the previous cell into the running best
    function automatic token_t resolve_pending(token_t t);
        token_t               r;
        logic [DIST_BITS-1:0] d;
        r = t;
        d = DIST_BITS'(t.pend_sx) + DIST_BITS'(t.pend_sy);
        if (t.pend_valid && ({1'b0, d} < t.best_dist))
        begin
            r.best_dist = {1'b0, d};
            r.best_x    = t.pend_x;
            r.best_y    = t.pend_y;
        end
        r.pend_valid = 1'b0;
        return r;
    endfunction

endpackage

// ===== sv/cpp_cell.sv =====
// ----------------------------------------------------------------------------
// cpp_cell
// One chain cell: holds one stored point, squares its distance to the
// passing point and merges the previous cell's squares into the best.
// ----------------------------------------------------------------------------
module cpp_cell #(
    parameter int MAX_POINTS = cpp_pkg::DEF_MAX_POINTS,
    parameter int CELL_IDX   = 0,
    parameter int IDX_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  cpp_pkg::token_t   tok_in,
    input  logic [IDX_W-1:0]  idx_in,
    output cpp_pkg::token_t   tok_out,
    output logic [IDX_W-1:0]  idx_out
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    cpp_pkg::coord_t                      px_reg;
    cpp_pkg::coord_t                      py_reg;
    cpp_pkg::token_t                      tok_reg;
    cpp_pkg::token_t                      tok_next;
    logic [IDX_W-1:0]                     idx_reg;
    logic                                 hit;
    logic                                 store;
    logic [cpp_pkg::COORD_BITS-1:0]       dx;
    logic [cpp_pkg::COORD_BITS-1:0]       dy;

    function automatic logic [cpp_pkg::COORD_BITS-1:0] abs_diff(
        cpp_pkg::coord_t a,
        cpp_pkg::coord_t b
    );
        logic signed [cpp_pkg::COORD_BITS:0] diff;
        logic signed [cpp_pkg::COORD_BITS:0] mag;
        diff = {a[cpp_pkg::COORD_BITS-1], a} - {b[cpp_pkg::COORD_BITS-1], b};
        mag  = diff[cpp_pkg::COORD_BITS] ? -diff : diff;
        return mag[cpp_pkg::COORD_BITS-1:0];
    endfunction

    assign hit   = tok_in.valid && (MY_IDX < idx_in);
    assign store = tok_in.valid && (MY_IDX == idx_in);
    assign dx    = abs_diff(px_reg, tok_in.x);
    assign dy    = abs_diff(py_reg, tok_in.y);

    always_comb
    begin
        tok_next            = cpp_pkg::resolve_pending(tok_in);
        tok_next.pend_valid = hit;
        tok_next.pend_sx    = cpp_pkg::SQ_BITS'(dx) * cpp_pkg::SQ_BITS'(dx);
        tok_next.pend_sy    = cpp_pkg::SQ_BITS'(dy) * cpp_pkg::SQ_BITS'(dy);
        tok_next.pend_x     = px_reg;
        tok_next.pend_y     = py_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
            idx_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
            idx_reg <= idx_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store)
        begin
            px_reg <= tok_in.x;
            py_reg <= tok_in.y;
        end
    end

    assign tok_out = tok_reg;
    assign idx_out = idx_reg;

endmodule

// ===== sv/closest_point_pair_core.sv =====
// ----------------------------------------------------------------------------
// closest_point_pair_core
// Streams 2D points into a chain of cells and reports the closest pair of
// each set with its squared distance.
//
// channel  | ports                  | handshake
// ---------+------------------------+------------------------------------
// points   | point                  | beat taken when start && !busy
// result   | result                 | one-cycle beat marked by done
//
// A stored point's beat walks all MAX_POINTS cells through their registers;
// the tail folds in the last squares as ST_WALK captures it, and ST_MERGE
// merges it with the set's best. A point dropped on a full store goes to
// ST_MERGE directly; a last point's result follows in the cycle after it.
// Reset clears the count, best and handshake state; the store is not cleared.
// done cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module closest_point_pair_core #(
    parameter int MAX_POINTS = cpp_pkg::DEF_MAX_POINTS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  cpp_pkg::point_in_t  point,
    output logic                done,
    output cpp_pkg::result_t    result
);

    `include "closest_point_pair_core_assert.svh"

    localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);
    localparam logic [CNT_W-1:0] CNT_TWO = CNT_W'(2);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_MERGE
    } state_t;

    state_t                           state_reg, state_next;
    logic [CNT_W-1:0]                 count_reg, count_next;
    logic                             ovf_reg, ovf_next;
    logic                             last_reg, last_next;
    logic [cpp_pkg::BEST_BITS-1:0]    gdist_reg, gdist_next;
    cpp_pkg::coord_t                  gfx_reg, gfx_next;
    cpp_pkg::coord_t                  gfy_reg, gfy_next;
    cpp_pkg::coord_t                  gsx_reg, gsx_next;
    cpp_pkg::coord_t                  gsy_reg, gsy_next;
    logic [cpp_pkg::BEST_BITS-1:0]    tdist_reg, tdist_next;
    cpp_pkg::coord_t                  tfx_reg, tfx_next;
    cpp_pkg::coord_t                  tfy_reg, tfy_next;
    cpp_pkg::coord_t                  tsx_reg, tsx_next;
    cpp_pkg::coord_t                  tsy_reg, tsy_next;
    logic                             busy_reg, busy_next;
    logic                             done_reg, done_next;
    cpp_pkg::result_t                 result_reg, result_next;

    cpp_pkg::token_t                  tok_w [0:MAX_POINTS];
    logic [IDX_W-1:0]                 idx_w [0:MAX_POINTS];
    cpp_pkg::token_t                  tail;
    logic                             accept;
    logic                             room;

    assign accept = start && !busy_reg;
    assign room   = count_reg < CNT_MAX;

    always_comb
    begin
        tok_w[0]           = '0;
        tok_w[0].valid     = accept && room;
        tok_w[0].x         = point.point_x;
        tok_w[0].y         = point.point_y;
        tok_w[0].best_dist = '1;
    end
    assign idx_w[0] = count_reg[IDX_W-1:0];

    for (genvar g = 0; g < MAX_POINTS; g++)
    begin : g_cell
        cpp_cell #(
            .MAX_POINTS (MAX_POINTS),
            .CELL_IDX   (g),
            .IDX_W      (IDX_W)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (tok_w[g]),
            .idx_in  (idx_w[g]),
            .tok_out (tok_w[g+1]),
            .idx_out (idx_w[g+1])
        );
    end

    assign tail = cpp_pkg::resolve_pending(tok_w[MAX_POINTS]);

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        ovf_next    = ovf_reg;
        last_next   = last_reg;
        gdist_next  = gdist_reg;
        gfx_next    = gfx_reg;
        gfy_next    = gfy_reg;
        gsx_next    = gsx_reg;
        gsy_next    = gsy_reg;
        tdist_next  = tdist_reg;
        tfx_next    = tfx_reg;
        tfy_next    = tfy_reg;
        tsx_next    = tsx_reg;
        tsy_next    = tsy_reg;
        done_next   = 1'b0;
        result_next = result_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    last_next = point.last_point;
                    if (room)
                    begin
                        count_next = count_reg + CNT_ONE;
                        state_next = ST_WALK;
                    end
                    else
                    begin
                        ovf_next   = 1'b1;
                        tdist_next = '1;
                        state_next = ST_MERGE;
                    end
                end
            end
            ST_WALK:
            begin
                if (tail.valid)
                begin
                    tdist_next = tail.best_dist;
                    tfx_next   = tail.best_x;
                    tfy_next   = tail.best_y;
                    tsx_next   = tail.x;
                    tsy_next   = tail.y;
                    state_next = ST_MERGE;
                end
            end
            ST_MERGE:
            begin
                if (tdist_reg < gdist_reg)
                begin
                    gdist_next = tdist_reg;
                    gfx_next   = tfx_reg;
                    gfy_next   = tfy_reg;
                    gsx_next   = tsx_reg;
                    gsy_next   = tsy_reg;
                end
                if (last_reg)
                begin
                    done_next = 1'b1;
                    if (count_reg >= CNT_TWO)
                    begin
                        result_next.first_x      = gfx_next;
                        result_next.first_y      = gfy_next;
                        result_next.second_x     = gsx_next;
                        result_next.second_y     = gsy_next;
                        result_next.dist_squared = gdist_next[cpp_pkg::DIST_BITS-1:0];
                        result_next.pair_valid   = 1'b1;
                    end
                    else
                    begin
                        result_next.first_x      = '0;
                        result_next.first_y      = '0;
                        result_next.second_x     = '0;
                        result_next.second_y     = '0;
                        result_next.dist_squared = '0;
                        result_next.pair_valid   = 1'b0;
                    end
                    result_next.overflowed = ovf_reg;
                    count_next = '0;
                    ovf_next   = 1'b0;
                    gdist_next = '1;
                    gfx_next   = '0;
                    gfy_next   = '0;
                    gsx_next   = '0;
                    gsy_next   = '0;
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        busy_next = (state_next != ST_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            ovf_reg    <= 1'b0;
            last_reg   <= 1'b0;
            gdist_reg  <= '1;
            gfx_reg    <= '0;
            gfy_reg    <= '0;
            gsx_reg    <= '0;
            gsy_reg    <= '0;
            busy_reg   <= 1'b0;
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            ovf_reg    <= ovf_next;
            last_reg   <= last_next;
            gdist_reg  <= gdist_next;
            gfx_reg    <= gfx_next;
            gfy_reg    <= gfy_next;
            gsx_reg    <= gsx_next;
            gsy_reg    <= gsy_next;
            busy_reg   <= busy_next;
            done_reg   <= done_next;
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tdist_reg  <= tdist_next;
        tfx_reg    <= tfx_next;
        tfy_reg    <= tfy_next;
        tsx_reg    <= tsx_next;
        tsy_reg    <= tsy_next;
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = result_reg;

    `CPP_ASSERT_NEXT(a_last_merge_gives_done, (state_reg == ST_MERGE) && last_reg, done_reg)
    `CPP_ASSERT_IMPL(a_done_while_open, done_reg, !busy_reg)
    `CPP_ASSERT_IMPL(a_tail_only_in_walk, tok_w[MAX_POINTS].valid, state_reg == ST_WALK)
    `CPP_ASSERT_NEXT(a_full_sets_overflow, accept && !room, ovf_reg)

endmodule
